// ----- design/assert_macros.svh -----
// Assertion helpers used by the srst_chk checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/srst_pkg.sv -----
`default_nettype none
package srst_pkg;
  localparam int STEP_W   = 24;
  localparam int VEL_W    = 24;
  localparam int TIME_W   = 32;
  localparam int VEL_FRAC = 8;

  // serial unit sizes
  localparam int SH_W  = 64;
  localparam int DSR_W = 30;
  localparam int REM_W = 32;
  localparam int CNT_W = 7;

  localparam logic [TIME_W-1:0] TIME_MAX   = '1;
  localparam logic [19:0]       US_PER_SEC = 20'd1000000;
  localparam logic [27:0]       ONE_SEC_Q  = 28'(64'd1000000 << VEL_FRAC);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PLAN = 2'd1,
    MODE_JOG  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAN = 2'd1,
    CMD_JOG  = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } sop_t;

  typedef struct packed {
    logic             start;
    sop_t             op;
    logic [CNT_W-1:0] iters;
    logic [SH_W-1:0]  sh;
    logic [DSR_W-1:0] dsr;
  } sreq_t;

  typedef struct packed {
    logic            done;
    logic [SH_W-1:0] res;
  } srsp_t;
endpackage
`default_nettype wire

// ----- design/srst_serial.sv -----
`default_nettype none
// Bit-serial restoring divider and digit-by-digit square root.
// Operand is left aligned in sh; one quotient/root bit per cycle.
module srst_serial (
  input  logic          clk,
  input  logic          rst_n,
  input  srst_pkg::sreq_t req,
  output srst_pkg::srsp_t rsp
);
  import srst_pkg::*;

  logic             busy_r;
  logic             done_r;
  sop_t             op_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SH_W-1:0]  sh_r;
  logic [REM_W-1:0] rem_r;
  logic [SH_W-1:0]  q_r;
  logic [DSR_W-1:0] dsr_r;

  logic [REM_W-1:0] trial_div, trial_sq, sub_sq, d_ext;

  always_comb begin
    trial_div = {rem_r[REM_W-2:0], sh_r[SH_W-1]};
    trial_sq  = {rem_r[REM_W-3:0], sh_r[SH_W-1:SH_W-2]};
    sub_sq    = {q_r[REM_W-3:0], 2'b01};
    d_ext     = REM_W'(dsr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= req.iters;
        sh_r   <= req.sh;
        dsr_r  <= req.dsr;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        unique case (op_r)
          OP_DIV: begin
            sh_r <= {sh_r[SH_W-2:0], 1'b0};
            if (trial_div >= d_ext) begin
              rem_r <= trial_div - d_ext;
              q_r   <= {q_r[SH_W-2:0], 1'b1};
            end else begin
              rem_r <= trial_div;
              q_r   <= {q_r[SH_W-2:0], 1'b0};
            end
          end
          OP_SQRT: begin
            sh_r <= {sh_r[SH_W-3:0], 2'b00};
            if (trial_sq >= sub_sq) begin
              rem_r <= trial_sq - sub_sq;
              q_r   <= {q_r[SH_W-2:0], 1'b1};
            end else begin
              rem_r <= trial_sq;
              q_r   <= {q_r[SH_W-2:0], 1'b0};
            end
          end
          default: ;
        endcase
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = q_r;
endmodule
`default_nettype wire

// ----- design/stepper_ramp_step_timer_top.sv -----
`default_nettype none
// Trapezoidal stepper ramp generator and step timer. Each input item carries a
// command (tick, plan move, start jog, stop jog) and a microsecond timestamp;
// exactly one result item comes back per input item, in order. Items are
// handled one at a time: in_stall is high from acceptance until the result
// has been placed in the output register, which then waits for the sink while
// the next item may already be taken. Handling time is set by the bit-serial
// divide/square-root unit, which produces one result bit per clock. Start/stop
// jog, idle ticks, zero-dt jog ticks and planned ticks that need no divide (no
// step due, final braking step, zero cruise speed) go straight to the output; a
// plan move multiplies and loads, then takes the 48-bit quotient of peak^2 /
// accel; a cruise step runs the 28-bit interval divide; an accelerating or
// braking step runs the 29-bit root, then the interval divide; a jog tick runs
// the 56-bit accel*dt / 1e6 quotient, the interval divide and a step check,
// and ends after the quotient when the jog comes to rest. Velocities are Q.8
// fixed point and intervals saturate at all ones when the speed is zero.
module stepper_ramp_step_timer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic [srst_pkg::TIME_W-1:0]     in_now_us,
  input  logic [srst_pkg::STEP_W-1:0]     in_move_steps,
  input  logic [srst_pkg::VEL_W-1:0]      in_peak_speed,
  input  logic [srst_pkg::VEL_W-1:0]      in_accel_rate,
  input  logic signed [srst_pkg::VEL_W-1:0] in_jog_target,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_step_pulse,
  output logic                            out_busy_res,
  output logic signed [srst_pkg::VEL_W-1:0] out_speed_now,
  output logic [srst_pkg::TIME_W-1:0]     out_interval_us
);
  import srst_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_LOAD = 6'b000100,
    S_WAIT = 6'b001000,
    S_JCHK = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // what the pending serial result is for
  typedef enum logic [2:0] {
    JOB_PLAN = 3'd0,  // ramp length quotient
    JOB_RAMP = 3'd1,  // ramp velocity root
    JOB_JOG  = 3'd2,  // jog velocity increment
    JOB_INT  = 3'd3,  // planned step interval
    JOB_JINT = 3'd4   // jog step interval
  } job_t;

  state_t state_r;
  job_t   job_r;
  logic   up_r;

  // block state
  mode_t                   mode_r;
  logic [TIME_W-1:0]       last_step_r, last_tick_r, ivl_r;
  logic [STEP_W-1:0]       sd_r, sim_r, rue_r, rds_r;
  logic signed [VEL_W-1:0] vel_r, tgt_r;
  logic [VEL_W-1:0]        acc_r, maxv_r;

  // per-item working registers
  logic [TIME_W-1:0] now_r;
  logic [STEP_W-1:0] n_r;
  logic [VEL_W-1:0]  p_r, a_r;
  logic [VEL_W-1:0]  mul_a_r;
  logic [TIME_W-1:0] mul_b_r;
  logic [VEL_W+TIME_W-1:0] prod_r;
  logic              pulse_r;

  sreq_t sreq_r;
  srsp_t srsp;

  logic                    out_valid_r, out_pulse_r, out_busy_r;
  logic signed [VEL_W-1:0] out_speed_r;
  logic [TIME_W-1:0]       out_ivl_r;

  srst_serial u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq_r),
    .rsp   (srsp)
  );

  logic              in_acc;
  logic [TIME_W-1:0] elapsed_in, dt_in, elapsed_r;
  logic [STEP_W-1:0] sd_inc, half, rue_new;
  logic [38:0]       rue_q;
  logic [28:0]       root, vramp;
  logic signed [26:0] vs, ts, diff, vsum;
  logic [26:0]       adiff, dv;
  logic signed [VEL_W-1:0] v_new;
  logic [VEL_W-1:0]  mag;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    elapsed_in = in_now_us - last_step_r;
    dt_in      = in_now_us - last_tick_r;
    elapsed_r  = now_r - last_step_r;
    sd_inc     = sd_r + 1'b1;

    // ramp-up end: (P^2 / A) >> (F+1), capped at half the move
    rue_q   = srsp.res[47:9];
    half    = {1'b0, n_r[STEP_W-1:1]};
    rue_new = (rue_q > 39'(half)) ? half : rue_q[STEP_W-1:0];

    root  = srsp.res[28:0];
    vramp = (up_r && (root > 29'(maxv_r))) ? 29'(maxv_r) : root;

    // jog slew, increment clamped so it never overshoots the target
    vs    = 27'(vel_r);
    ts    = 27'(tgt_r);
    dv    = (|srsp.res[63:25]) ? 27'd33554432 : {2'b00, srsp.res[24:0]};
    diff  = ts - vs;
    adiff = diff[26] ? 27'(-diff) : 27'(diff);
    if (vs < ts)      vsum = (dv >= adiff) ? ts : vs + $signed(dv);
    else if (vs > ts) vsum = (dv >= adiff) ? ts : vs - $signed(dv);
    else              vsum = vs;
    v_new = vsum[VEL_W-1:0];
    mag   = v_new[VEL_W-1] ? VEL_W'(-v_new) : VEL_W'(v_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_IDLE;
      last_step_r  <= '0;
      last_tick_r  <= '0;
      ivl_r        <= '0;
      sd_r         <= '0;
      sim_r        <= '0;
      rue_r        <= '0;
      rds_r        <= '0;
      vel_r        <= '0;
      tgt_r        <= '0;
      acc_r        <= '0;
      maxv_r       <= '0;
      sreq_r.start <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // start is a one-cycle strobe; no new request is issued while it is high
      if (sreq_r.start) sreq_r.start <= 1'b0;
      // S_DONE handles the output register itself
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            last_tick_r <= in_now_us;
            now_r       <= in_now_us;
            pulse_r     <= (cmd_t'(in_cmd) == CMD_TICK) && (mode_r == MODE_PLAN) &&
                           (elapsed_in >= ivl_r);
            unique case (cmd_t'(in_cmd))
              CMD_PLAN: begin
                if (in_move_steps == '0 || in_accel_rate == '0) begin
                  mode_r  <= MODE_IDLE;
                  state_r <= S_DONE;
                end else begin
                  n_r     <= in_move_steps;
                  p_r     <= in_peak_speed;
                  a_r     <= in_accel_rate;
                  mul_a_r <= in_peak_speed;
                  mul_b_r <= TIME_W'(in_peak_speed);
                  job_r   <= JOB_PLAN;
                  state_r <= S_MUL;
                end
              end
              CMD_JOG: begin
                acc_r   <= in_accel_rate;
                tgt_r   <= in_jog_target;
                mode_r  <= MODE_JOG;
                state_r <= S_DONE;
              end
              CMD_STOP: begin
                tgt_r   <= '0;
                state_r <= S_DONE;
              end
              CMD_TICK: begin
                unique case (mode_r)
                  MODE_PLAN: begin
                    if (elapsed_in >= ivl_r) begin
                      last_step_r <= in_now_us;
                      sd_r        <= sd_inc;
                      if (sd_inc <= rue_r) begin
                        mul_a_r <= acc_r;
                        mul_b_r <= TIME_W'(sd_inc);
                        up_r    <= 1'b1;
                        job_r   <= JOB_RAMP;
                        state_r <= S_MUL;
                      end else if (sd_inc >= rds_r) begin
                        if (sd_inc >= sim_r) begin
                          mode_r  <= MODE_IDLE;  // last braking step
                          state_r <= S_DONE;
                        end else begin
                          mul_a_r <= acc_r;
                          mul_b_r <= TIME_W'(sim_r - sd_inc);
                          up_r    <= 1'b0;
                          job_r   <= JOB_RAMP;
                          state_r <= S_MUL;
                        end
                      end else if (maxv_r == '0) begin
                        ivl_r   <= TIME_MAX;
                        state_r <= S_DONE;
                      end else begin
                        sreq_r  <= '{1'b1, OP_DIV, CNT_W'(28), {ONE_SEC_Q, 36'b0},
                                    DSR_W'(maxv_r)};
                        job_r   <= JOB_INT;
                        state_r <= S_WAIT;
                      end
                    end else begin
                      state_r <= S_DONE;
                    end
                  end
                  MODE_JOG: begin
                    if (dt_in != '0) begin
                      mul_a_r <= acc_r;
                      mul_b_r <= dt_in;
                      job_r   <= JOB_JOG;
                      state_r <= S_MUL;
                    end else begin
                      state_r <= S_DONE;
                    end
                  end
                  default: state_r <= S_DONE;
                endcase
              end
              default: state_r <= S_DONE;
            endcase
          end
        end

        S_MUL: begin
          prod_r  <= mul_a_r * mul_b_r;
          state_r <= S_LOAD;
        end

        S_LOAD: begin
          state_r <= S_WAIT;
          case (job_r)
            JOB_PLAN: sreq_r <= '{1'b1, OP_DIV, CNT_W'(48), {prod_r[47:0], 16'b0},
                                  DSR_W'(a_r)};
            JOB_RAMP: sreq_r <= '{1'b1, OP_SQRT, CNT_W'(29),
                                  {1'b0, prod_r[47:0], 15'b0}, '0};
            default:  sreq_r <= '{1'b1, OP_DIV, CNT_W'(56), {prod_r, 8'b0},
                                  DSR_W'(US_PER_SEC)};
          endcase
        end

        S_WAIT: begin
          if (srsp.done) begin
            case (job_r)
              JOB_PLAN: begin
                sim_r       <= n_r;
                sd_r        <= '0;
                acc_r       <= a_r;
                maxv_r      <= p_r;
                rue_r       <= rue_new;
                rds_r       <= n_r - rue_new;
                last_step_r <= now_r;
                ivl_r       <= '0;
                mode_r      <= MODE_PLAN;
                state_r     <= S_DONE;
              end
              JOB_RAMP: begin
                if (vramp == '0) begin
                  ivl_r   <= TIME_MAX;
                  state_r <= S_DONE;
                  if (sd_r >= sim_r) mode_r <= MODE_IDLE;
                end else begin
                  sreq_r  <= '{1'b1, OP_DIV, CNT_W'(28), {ONE_SEC_Q, 36'b0},
                              DSR_W'(vramp)};
                  job_r   <= JOB_INT;
                  state_r <= S_WAIT;
                end
              end
              JOB_JOG: begin
                vel_r <= v_new;
                if (v_new == '0 && tgt_r == '0) begin
                  mode_r  <= MODE_IDLE;  // jog has come to rest
                  state_r <= S_DONE;
                end else if (mag == '0) begin
                  ivl_r   <= TIME_MAX;
                  state_r <= S_JCHK;
                end else begin
                  sreq_r  <= '{1'b1, OP_DIV, CNT_W'(28), {ONE_SEC_Q, 36'b0},
                              DSR_W'(mag)};
                  job_r   <= JOB_JINT;
                  state_r <= S_WAIT;
                end
              end
              JOB_INT: begin
                ivl_r   <= srsp.res[TIME_W-1:0];
                state_r <= S_DONE;
                if (sd_r >= sim_r) mode_r <= MODE_IDLE;
              end
              default: begin
                ivl_r   <= srsp.res[TIME_W-1:0];
                state_r <= S_JCHK;
              end
            endcase
          end
        end

        S_JCHK: begin
          if (elapsed_r >= ivl_r) begin
            last_step_r <= now_r;
            pulse_r     <= 1'b1;
          end
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_pulse_r <= pulse_r;
            out_busy_r  <= (mode_r == MODE_PLAN) || (mode_r == MODE_JOG);
            out_speed_r <= vel_r;
            out_ivl_r   <= ivl_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_step_pulse  = out_pulse_r;
  assign out_busy_res    = out_busy_r;
  assign out_speed_now   = out_speed_r;
  assign out_interval_us = out_ivl_r;
endmodule
`default_nettype wire

// ----- design/srst_chk.sv -----
`default_nettype none
`include "assert_macros.svh"
module srst_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_step_pulse,
  input logic                              out_busy_res,
  input logic signed [srst_pkg::VEL_W-1:0] out_speed_now,
  input logic [srst_pkg::TIME_W-1:0]       out_interval_us
);
  // one item in flight: the block closes its input after taking an item
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "no stall after accept")
  // a new result is only posted as the block reopens its input
  `CHK_SAME(a_post_opens_input, clk, rst_n, $rose(out_valid), !in_stall, "result posted while busy")
  // waiting result holds
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_interval_us) && $stable(out_speed_now) && $stable(out_step_pulse) && $stable(out_busy_res), "stalled result changed")
endmodule
bind stepper_ramp_step_timer_top srst_chk u_srst_chk (.*);
`default_nettype wire
